### design/isu_pkg.sv
// Package for the integer stack unit: shared widths, operation and status
// codes, and the command word that passes from the front end to the back end.
// No dependencies.
package isu_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int FUNC_W        = 3;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int CMDQ_DEPTH    = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH  = 3'd0,
        FUNC_PRINT = 3'd1,
        FUNC_PEEK  = 3'd2,
        FUNC_POP   = 3'd3,
        FUNC_SWAP  = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_SHORT = 2'd2,
        ST_FULL  = 2'd3
    } result_code_t;

    typedef struct packed {
        func_t                     op;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

endpackage

### design/integer_stack_unit_top.sv
// Top level of the integer stack unit: joins the front end and the back end.
// Depends on isu_pkg, isu_front and isu_back.
//
// A bounded stack of signed 32-bit integers, one operation code per input
// beat. A beat (func, push_value) is taken at an edge where push is high and
// full is low; unused codes are taken and dropped without any result. While
// empty is low the oldest result (status, entry_value, has_value, last) is on
// the ports and is taken at an edge where pop is high. Every operation ends
// with a beat whose last flag is set; print all gives one beat per entry, top
// first.
//
// A command waits in a two-entry queue before the back end runs it. Push, pop
// and any operation that fails or finds the stack empty go straight to the
// result register; peek and print all pass through the read state S_RD_EMIT,
// print all at one entry per cycle while pop is high, and swap through
// S_SW_RD1, S_SW_RD2 and S_SW_WR. The stack memory has one write port and one
// registered read port, so peek spends a read, print one read per entry and
// swap two reads and two writes; back-to-back push or pop commands run at one
// per cycle while pop is high. Reset clears the entry count, the queues and the
// sequencer, not the stack memory. When the receiver holds pop low the result
// stays put, the back end waits, and full rises once the command queue fills.
module integer_stack_unit_top #(
    parameter int DEPTH = isu_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [isu_pkg::FUNC_W-1:0]          func,
    input  logic signed [isu_pkg::VALUE_W-1:0]  push_value,
    output logic                                empty,
    input  logic                                pop,
    output logic [isu_pkg::STATUS_W-1:0]        status,
    output logic signed [isu_pkg::VALUE_W-1:0]  entry_value,
    output logic                                has_value,
    output logic                                last
);
    import isu_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;

    isu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .func       (func),
        .push_value (push_value),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take)
    );

    isu_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_take    (cmd_take),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .entry_value (entry_value),
        .has_value   (has_value),
        .last        (last)
    );

endmodule

### design/isu_front.sv
// Front end of the integer stack unit: accepts input beats, drops unused
// operation codes and holds decoded commands in a short queue.
// Depends on isu_pkg.
module isu_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [isu_pkg::FUNC_W-1:0]          func,
    input  logic signed [isu_pkg::VALUE_W-1:0]  push_value,
    output logic                                cmd_valid,
    output isu_pkg::cmd_t                       cmd,
    input  logic                                cmd_take
);
    import isu_pkg::*;

    localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int NW = $clog2(CMDQ_DEPTH + 1);

    cmd_t            q_reg [CMDQ_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   cnt_reg, cnt_next;
    logic            code_ok;
    logic            enq;
    logic            deq;
    cmd_t            new_cmd;

    // Codes outside the operation set are accepted and then dropped.
    assign code_ok   = func inside {[FUNC_PUSH:FUNC_SWAP]};
    assign full      = (cnt_reg == NW'(CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign enq       = push && !full && code_ok;
    assign deq       = cmd_take && cmd_valid;

    always_comb
    begin
        new_cmd.op    = func_t'(func);
        new_cmd.value = push_value;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        cnt_next      = cnt_reg;
        if (enq)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (deq)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (enq && !deq)
        begin
            cnt_next = cnt_reg + NW'(1);
        end
        else if (deq && !enq)
        begin
            cnt_next = cnt_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

### design/isu_back.sv
// Back end of the integer stack unit: stack memory, entry count, the
// sequencer that carries out commands, and the result output register.
// Depends on isu_pkg.
module isu_back #(
    parameter int DEPTH = isu_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    input  isu_pkg::cmd_t                       cmd,
    output logic                                cmd_take,
    output logic                                empty,
    input  logic                                pop,
    output logic [isu_pkg::STATUS_W-1:0]        status,
    output logic signed [isu_pkg::VALUE_W-1:0]  entry_value,
    output logic                                has_value,
    output logic                                last
);
    import isu_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SW_RD1  = 5'b00010,
        S_SW_RD2  = 5'b00100,
        S_SW_WR   = 5'b01000,
        S_RD_EMIT = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [AW-1:0]              idx_reg, idx_next;
    logic                       peek_reg, peek_next;
    logic signed [VALUE_W-1:0]  hold_reg, hold_next;

    logic signed [VALUE_W-1:0]  mem [DEPTH];
    logic signed [VALUE_W-1:0]  rd_data_reg;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic signed [VALUE_W-1:0]  wr_data;

    logic                       out_valid_reg;
    result_code_t               out_status_reg;
    logic signed [VALUE_W-1:0]  out_value_reg;
    logic                       out_has_reg;
    logic                       out_last_reg;

    logic                       out_free;
    logic                       emit;
    result_code_t               emit_status;
    logic signed [VALUE_W-1:0]  emit_value;
    logic                       emit_has;
    logic                       emit_last;
    logic [CW-1:0]              top_idx;
    logic [CW-1:0]              second_idx;
    logic                       is_full;
    logic                       is_empty;

    assign out_free    = !out_valid_reg || pop;
    assign top_idx     = count_reg - CW'(1);
    assign second_idx  = count_reg - CW'(2);
    assign is_full     = (count_reg == CW'(DEPTH));
    assign is_empty    = (count_reg == '0);

    assign empty       = !out_valid_reg;
    assign status      = out_status_reg;
    assign entry_value = out_value_reg;
    assign has_value   = out_has_reg;
    assign last        = out_last_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        peek_next   = peek_reg;
        hold_next   = hold_reg;
        cmd_take    = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = idx_reg;
        wr_en       = 1'b0;
        wr_addr     = count_reg[AW-1:0];
        wr_data     = cmd.value;
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_value  = '0;
        emit_has    = 1'b0;
        emit_last   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_take = 1'b1;
                    case (cmd.op)
                        FUNC_PUSH:
                        begin
                            emit = 1'b1;
                            if (is_full)
                            begin
                                emit_status = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        FUNC_PRINT, FUNC_PEEK:
                        begin
                            if (is_empty)
                            begin
                                emit        = 1'b1;
                                emit_status = (cmd.op == FUNC_PEEK) ? ST_EMPTY : ST_OK;
                            end
                            else
                            begin
                                idx_next   = top_idx[AW-1:0];
                                rd_en      = 1'b1;
                                rd_addr    = top_idx[AW-1:0];
                                peek_next  = (cmd.op == FUNC_PEEK);
                                state_next = S_RD_EMIT;
                            end
                        end
                        FUNC_POP:
                        begin
                            emit = 1'b1;
                            if (is_empty)
                            begin
                                emit_status = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        FUNC_SWAP:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                emit        = 1'b1;
                                emit_status = ST_SHORT;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = top_idx[AW-1:0];
                                state_next = S_SW_RD1;
                            end
                        end
                        default:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            S_SW_RD1:
            begin
                // Top entry is on the read port; fetch the one below it.
                hold_next  = rd_data_reg;
                rd_en      = 1'b1;
                rd_addr    = second_idx[AW-1:0];
                state_next = S_SW_RD2;
            end
            S_SW_RD2:
            begin
                wr_en      = 1'b1;
                wr_addr    = top_idx[AW-1:0];
                wr_data    = rd_data_reg;
                state_next = S_SW_WR;
            end
            S_SW_WR:
            begin
                if (out_free)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = second_idx[AW-1:0];
                    wr_data    = hold_reg;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RD_EMIT:
            begin
                // The entry at idx_reg is on the read port.
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_value = rd_data_reg;
                    emit_has   = 1'b1;
                    emit_last  = peek_reg || (idx_reg == '0);
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - AW'(1);
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg - AW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        peek_reg <= peek_next;
        hold_reg <= hold_next;
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_value_reg  <= emit_value;
            out_has_reg    <= emit_has;
            out_last_reg   <= emit_last;
        end
    end

    // Stack memory: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

### bench/integer_stack_unit_top_tb.sv
// Testbench for integer_stack_unit_top: random and directed stack operations with
// checking of every result beat against a stack predictor kept in the bench.
// Depends on isu_pkg and the integer_stack_unit_top RTL.
module integer_stack_unit_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import isu_pkg::*;

    localparam int STACK_DEPTH = DEPTH_DEFAULT;

    // One input beat: the operation code is kept as raw bits so that the
    // unused codes 5 to 7 can be sent as well.
    typedef struct {
        logic [FUNC_W-1:0]          op;
        logic signed [VALUE_W-1:0]  value;
    } stack_cmd_t;

    // One result beat as the block should present it.
    typedef struct {
        result_code_t               status;
        logic signed [VALUE_W-1:0]  value;
        logic                       has_value;
        logic                       last;
    } stack_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    logic [FUNC_W-1:0]          func = '0;
    logic signed [VALUE_W-1:0]  push_value = '0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  entry_value;
    logic                       has_value;
    logic                       last;

    // Commands waiting to be sent and result beats owed by the block.
    stack_cmd_t     op_queue[$];
    stack_result_t  owed_results[$];

    // Bench copy of the stack, updated when a command beat is accepted.
    logic signed [VALUE_W-1:0]  stack_mem [STACK_DEPTH];
    int                         stack_level = 0;

    // Stack level as the stimulus generator sees it; it follows the same
    // sequence of operations, so it tracks stack_level ahead of time.
    int                         gen_level = 0;

    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     error_count = 0;
    logic   beat_taken = 1'b0;

    integer_stack_unit_top #(
        .DEPTH (STACK_DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .func        (func),
        .push_value  (push_value),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .entry_value (entry_value),
        .has_value   (has_value),
        .last        (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Reset is held low from the start and released on a falling edge.
    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
    end

    // The timeout only fires if the block stops producing or accepting beats.
    initial
    begin
        #30_000_000;
        $display("Timeout at %0t", $realtime);
        $display("Test completed with failures");
        $finish;
    end

    task automatic owe_result(result_code_t st, logic signed [VALUE_W-1:0] val, logic has,
                              logic fin);
        stack_result_t r;
        r.status    = st;
        r.value     = val;
        r.has_value = has;
        r.last      = fin;
        owed_results.push_back(r);
    endtask

    // Applies one accepted command to the bench stack and queues the result
    // beats that the block owes for it. Unused codes change nothing and owe
    // nothing.
    task automatic apply_stack_op(logic [FUNC_W-1:0] op, logic signed [VALUE_W-1:0] val);
        logic signed [VALUE_W-1:0] swap_tmp;
        case (op)
            FUNC_PUSH:
            begin
                if (stack_level == STACK_DEPTH)
                begin
                    owe_result(ST_FULL, '0, 1'b0, 1'b1);
                end
                else
                begin
                    stack_mem[stack_level] = val;
                    stack_level++;
                    owe_result(ST_OK, '0, 1'b0, 1'b1);
                end
            end
            FUNC_PRINT:
            begin
                // Top first; only the bottom entry carries the last flag.
                if (stack_level == 0)
                begin
                    owe_result(ST_OK, '0, 1'b0, 1'b1);
                end
                else
                begin
                    for (int i = stack_level - 1; i >= 0; i--)
                    begin
                        owe_result(ST_OK, stack_mem[i], 1'b1, i == 0);
                    end
                end
            end
            FUNC_PEEK:
            begin
                if (stack_level == 0)
                begin
                    owe_result(ST_EMPTY, '0, 1'b0, 1'b1);
                end
                else
                begin
                    owe_result(ST_OK, stack_mem[stack_level - 1], 1'b1, 1'b1);
                end
            end
            FUNC_POP:
            begin
                if (stack_level == 0)
                begin
                    owe_result(ST_EMPTY, '0, 1'b0, 1'b1);
                end
                else
                begin
                    stack_level--;
                    owe_result(ST_OK, '0, 1'b0, 1'b1);
                end
            end
            FUNC_SWAP:
            begin
                if (stack_level < 2)
                begin
                    owe_result(ST_SHORT, '0, 1'b0, 1'b1);
                end
                else
                begin
                    swap_tmp                   = stack_mem[stack_level - 1];
                    stack_mem[stack_level - 1] = stack_mem[stack_level - 2];
                    stack_mem[stack_level - 2] = swap_tmp;
                    owe_result(ST_OK, '0, 1'b0, 1'b1);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Queues one command for the driver and keeps the generator's view of the
    // stack level in step with it.
    task automatic send_op(logic [FUNC_W-1:0] op, logic signed [VALUE_W-1:0] val);
        stack_cmd_t c;
        c.op    = op;
        c.value = val;
        op_queue.push_back(c);
        if (op == FUNC_PUSH && gen_level < STACK_DEPTH)
        begin
            gen_level++;
        end
        else if (op == FUNC_POP && gen_level > 0)
        begin
            gen_level--;
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            return {1'b1, {(VALUE_W-1){1'b0}}};
        end
        else if (r < 10)
        begin
            return {1'b0, {(VALUE_W-1){1'b1}}};
        end
        else if (r < 25)
        begin
            return $signed($urandom_range(0, 31)) - 16;
        end
        return $signed($urandom);
    endfunction

    // Random commands in two moods: filling pushes the stack up to the top,
    // draining pulls it back down to nothing. The mood flips with some delay
    // after the stack hits full or empty, so that push on a full stack and
    // pop, peek and swap on a short stack all come up. A few unused codes are
    // mixed in; they do not count toward the number of commands.
    task automatic send_random_ops(int count);
        static bit filling = 1'b1;
        int sent;
        int r;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 4)
            begin
                send_op(FUNC_W'($urandom_range(5, 7)), pick_value());
                continue;
            end
            if (filling && gen_level == STACK_DEPTH && $urandom_range(0, 3) == 0)
            begin
                filling = 1'b0;
            end
            else if (!filling && gen_level == 0 && $urandom_range(0, 3) == 0)
            begin
                filling = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (filling)
            begin
                if (r < 55)
                    send_op(FUNC_PUSH, pick_value());
                else if (r < 62)
                    send_op(FUNC_PRINT, pick_value());
                else if (r < 73)
                    send_op(FUNC_PEEK, pick_value());
                else if (r < 88)
                    send_op(FUNC_POP, pick_value());
                else
                    send_op(FUNC_SWAP, pick_value());
            end
            else
            begin
                if (r < 15)
                    send_op(FUNC_PUSH, pick_value());
                else if (r < 21)
                    send_op(FUNC_PRINT, pick_value());
                else if (r < 32)
                    send_op(FUNC_PEEK, pick_value());
                else if (r < 80)
                    send_op(FUNC_POP, pick_value());
                else
                    send_op(FUNC_SWAP, pick_value());
            end
            sent++;
        end
    endtask

    // Driver: on each falling edge it retires the command taken at the last
    // rising edge, then offers the next one unless the sender idles.
    always @(negedge clk)
    begin : drive_cmds
        logic offer;
        if (beat_taken)
        begin
            void'(op_queue.pop_front());
            beat_taken = 1'b0;
        end
        offer = (op_queue.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct);
        push <= offer;
        if (offer)
        begin
            func       <= op_queue[0].op;
            push_value <= op_queue[0].value;
        end
    end

    // The receiver stalls at random; pop is ignored by the block while empty.
    always @(negedge clk)
    begin
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: at each rising edge it records an accepted command in the
    // predictor and checks an accepted result beat against the oldest one owed.
    // A command's results pass through the command queue and the result register
    // before they can be taken, so predicting first at the same edge is safe.
    always @(posedge clk)
    begin : watch_ports
        stack_result_t want;
        if (rst_n)
        begin
            if (push && !full)
            begin
                apply_stack_op(func, push_value);
                beat_taken = 1'b1;
            end
            if (pop && !empty)
            begin
                if (owed_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result beat: status %0d value %0d",
                             $realtime, status, entry_value);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (status !== want.status)
                    begin
                        error_count++;
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $realtime, want.status, status);
                    end
                    if (entry_value !== want.value)
                    begin
                        error_count++;
                        $display("%0t: entry_value mismatch: expected %0d, got %0d",
                                 $realtime, want.value, entry_value);
                    end
                    if (has_value !== want.has_value)
                    begin
                        error_count++;
                        $display("%0t: has_value mismatch: expected %0b, got %0b",
                                 $realtime, want.has_value, has_value);
                    end
                    if (last !== want.last)
                    begin
                        error_count++;
                        $display("%0t: last mismatch: expected %0b, got %0b",
                                 $realtime, want.last, last);
                    end
                end
            end
        end
    end

    // Stimulus: a directed opening, then random commands over four idling
    // phases. A phase ends when the driver has sent all of its commands.
    initial
    begin : stimulus
        int guard;
        wait (rst_n);
        @(negedge clk);

        // Every operation on an empty stack, then the value extremes, swap with
        // a single entry, print of several entries, the unused codes, and a
        // final drain down to an empty print.
        send_op(FUNC_PRINT, '0);
        send_op(FUNC_PEEK, '0);
        send_op(FUNC_POP, '0);
        send_op(FUNC_SWAP, '0);
        send_op(FUNC_PUSH, {1'b1, {(VALUE_W-1){1'b0}}});
        send_op(FUNC_SWAP, '1);
        send_op(FUNC_PEEK, '0);
        send_op(FUNC_PUSH, {1'b0, {(VALUE_W-1){1'b1}}});
        send_op(FUNC_PUSH, '1);
        send_op(FUNC_PUSH, '0);
        send_op(FUNC_PEEK, '0);
        send_op(FUNC_SWAP, '0);
        send_op(FUNC_PRINT, '0);
        send_op(FUNC_POP, '0);
        send_op(FUNC_PEEK, '0);
        send_op(3'd5, '1);
        send_op(3'd6, '0);
        send_op(3'd7, '1);
        send_op(FUNC_PRINT, '1);
        send_op(FUNC_POP, '0);
        send_op(FUNC_POP, '0);
        send_op(FUNC_POP, '0);
        send_op(FUNC_PRINT, '0);
        while (op_queue.size() != 0)
            @(posedge clk);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_ops(120);
        while (op_queue.size() != 0)
            @(posedge clk);

        send_idle_pct  = 76;
        recv_stall_pct = 0;
        send_random_ops(120);
        while (op_queue.size() != 0)
            @(posedge clk);

        send_idle_pct  = 0;
        recv_stall_pct = 76;
        send_random_ops(120);
        while (op_queue.size() != 0)
            @(posedge clk);

        send_idle_pct  = 9;
        recv_stall_pct = 9;
        send_random_ops(120);
        while (op_queue.size() != 0)
            @(posedge clk);

        // Let the owed results drain, with a bound, then keep watching the ports
        // in case the block sends something nobody asked for.
        for (guard = 0; guard < 200000 && owed_results.size() != 0; guard++)
            @(posedge clk);
        if (owed_results.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d result beats never arrived", $realtime, owed_results.size());
        end
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
design/isu_pkg.sv
design/isu_front.sv
design/isu_back.sv
design/integer_stack_unit_top.sv
bench/integer_stack_unit_top_tb.sv
